FILE: src/dssm_pkg.sv
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and constants for the drive safety state machine.
// ----------------------------------------------------------------------------
package dssm_pkg;

  // drive modes, also the encoding of the drive_mode result field
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_RUN       = 3'd1,
    MODE_LIMP      = 3'd2,
    MODE_SOFT_STOP = 3'd3,
    MODE_LOCKED    = 3'd4
  } mode_t;

  // safety levels
  localparam logic [1:0] LVL_SAFE      = 2'd0;
  localparam logic [1:0] LVL_WARN      = 2'd1;
  localparam logic [1:0] LVL_LIMP      = 2'd2;
  localparam logic [1:0] LVL_EMERGENCY = 2'd3;

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMP_RECOVER = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SOFT_TIMEOUT = 8'd1;

  localparam logic [31:0] LIMP_RECOVER_RST = 32'd1000;
  localparam logic [31:0] SOFT_TIMEOUT_RST = 32'd2000;

  // 70 percent derate: x * 7 / 10, the divide by 10 done as
  // multiply by ceil(2^19 / 10), exact for dividends below 2^18
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               system_active;
    logic [1:0]         safety_level;
    logic signed [15:0] demand_left;
    logic signed [15:0] demand_right;
    logic signed [15:0] actual_left;
    logic signed [15:0] actual_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic [2:0]         drive_mode;
    logic               clear_ramps;
  } out_item_t;

endpackage

FILE: src/dssm_in_if.sv
// ----------------------------------------------------------------------------
// dssm_in_if
// Input tick channel: valid/ready with one tick of sensor and demand data.
// ----------------------------------------------------------------------------
interface dssm_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               system_active;
  logic [1:0]         safety_level;
  logic signed [15:0] demand_left;
  logic signed [15:0] demand_right;
  logic signed [15:0] actual_left;
  logic signed [15:0] actual_right;

  modport source (
    output valid, now_ms, system_active, safety_level,
    output demand_left, demand_right, actual_left, actual_right,
    input  ready
  );
  modport sink (
    input  valid, now_ms, system_active, safety_level,
    input  demand_left, demand_right, actual_left, actual_right,
    output ready
  );
endinterface

FILE: src/dssm_out_if.sv
// ----------------------------------------------------------------------------
// dssm_out_if
// Result channel: valid/ready with drive targets, mode and ramp clear.
// ----------------------------------------------------------------------------
interface dssm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_left;
  logic signed [15:0] target_right;
  logic [2:0]         drive_mode;
  logic               clear_ramps;

  modport source (
    output valid, target_left, target_right, drive_mode, clear_ramps,
    input  ready
  );
  modport sink (
    input  valid, target_left, target_right, drive_mode, clear_ramps,
    output ready
  );
endinterface

FILE: src/dssm_cfg_if.sv
// ----------------------------------------------------------------------------
// dssm_cfg_if
// Configuration write channel: valid/ready with register address and data.
// ----------------------------------------------------------------------------
interface dssm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dssm_pkg::CFG_ADDR_W-1:0] addr;
  logic [31:0]                     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: src/dssm_core.sv
// ----------------------------------------------------------------------------
// dssm_core
// Mode state, timers and configuration registers; computes one result per
// tick from the registered input and advances state when step is high.
// ----------------------------------------------------------------------------
module dssm_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  dssm_pkg::in_item_t              item,
  output dssm_pkg::out_item_t             res,
  input  logic                            cfg_we,
  input  logic [dssm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                     cfg_data
);

  dssm_pkg::mode_t mode, mode_next;
  logic [31:0]     recover_window_ms;
  logic [31:0]     soft_stop_timeout_ms;
  logic [31:0]     limp_safe_since, limp_safe_since_next;
  logic            limp_timing, limp_timing_next;
  logic [31:0]     soft_stop_since, soft_stop_since_next;

  logic [31:0]        limp_elapsed;
  logic [31:0]        soft_elapsed;
  logic               outputs_zero;
  logic signed [15:0] tl, tr;
  logic               clr;

  // x * 0.7 truncated toward zero
  function automatic logic signed [15:0] derate(input logic signed [15:0] d);
    logic [16:0] mag;
    logic [17:0] mag7;
    logic [33:0] prod;
    logic [14:0] q;
    mag  = d[15] ? (17'd0 - {d[15], d}) : {1'b0, d};
    mag7 = 18'({mag, 3'b000}) - 18'(mag);
    prod = mag7 * dssm_pkg::DIV10_MUL;
    q    = prod[dssm_pkg::DIV10_SHIFT +: 15];
    return d[15] ? (16'd0 - {1'b0, q}) : {1'b0, q};
  endfunction

  // x / 2 truncated toward zero
  function automatic logic signed [15:0] halve(input logic signed [15:0] d);
    logic signed [16:0] t;
    t = {d[15], d} + {16'd0, d[15]};
    return t[16:1];
  endfunction

  assign limp_elapsed = item.now_ms - limp_safe_since;
  assign soft_elapsed = item.now_ms - soft_stop_since;
  assign outputs_zero = (item.actual_left == 16'sd0) && (item.actual_right == 16'sd0);

  // next state
  always_comb begin
    mode_next            = mode;
    limp_timing_next     = limp_timing;
    limp_safe_since_next = limp_safe_since;
    case (mode)
      dssm_pkg::MODE_IDLE: begin
        limp_timing_next     = 1'b0;
        limp_safe_since_next = '0;
        if (item.system_active) begin
          mode_next = dssm_pkg::MODE_RUN;
        end
      end
      dssm_pkg::MODE_RUN: begin
        if (item.safety_level == dssm_pkg::LVL_EMERGENCY) begin
          mode_next = dssm_pkg::MODE_SOFT_STOP;
        end else if (item.safety_level == dssm_pkg::LVL_LIMP) begin
          mode_next            = dssm_pkg::MODE_LIMP;
          limp_timing_next     = 1'b0;
          limp_safe_since_next = '0;
        end
      end
      dssm_pkg::MODE_LIMP: begin
        if (item.safety_level == dssm_pkg::LVL_EMERGENCY) begin
          mode_next = dssm_pkg::MODE_SOFT_STOP;
        end else if (item.safety_level == dssm_pkg::LVL_SAFE) begin
          if (!limp_timing) begin
            limp_timing_next     = 1'b1;
            limp_safe_since_next = item.now_ms;
          end else if (limp_elapsed >= recover_window_ms) begin
            mode_next            = dssm_pkg::MODE_RUN;
            limp_timing_next     = 1'b0;
            limp_safe_since_next = '0;
          end
        end else begin
          limp_timing_next     = 1'b0;
          limp_safe_since_next = '0;
        end
      end
      dssm_pkg::MODE_SOFT_STOP: begin
        if (outputs_zero || (soft_elapsed >= soft_stop_timeout_ms)) begin
          mode_next = dssm_pkg::MODE_LOCKED;
        end
      end
      default: begin
        mode_next = dssm_pkg::MODE_LOCKED;
      end
    endcase
  end

  // soft stop start time is taken on the tick that enters soft stop
  always_comb begin
    soft_stop_since_next = soft_stop_since;
    if ((mode_next == dssm_pkg::MODE_SOFT_STOP) && (mode != dssm_pkg::MODE_SOFT_STOP)) begin
      soft_stop_since_next = item.now_ms;
    end
  end

  // outputs of the tick
  always_comb begin
    tl  = 16'sd0;
    tr  = 16'sd0;
    clr = 1'b0;
    case (mode)
      dssm_pkg::MODE_IDLE: begin
        clr = 1'b1;
      end
      dssm_pkg::MODE_RUN: begin
        if (item.safety_level == dssm_pkg::LVL_WARN) begin
          tl = derate(item.demand_left);
          tr = derate(item.demand_right);
        end else begin
          tl = item.demand_left;
          tr = item.demand_right;
        end
      end
      dssm_pkg::MODE_LIMP: begin
        tl = halve(item.demand_left);
        tr = halve(item.demand_right);
      end
      default: begin
        tl = 16'sd0;
      end
    endcase
  end

  assign res.target_left  = tl;
  assign res.target_right = tr;
  assign res.drive_mode   = mode_next;
  assign res.clear_ramps  = clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= dssm_pkg::MODE_IDLE;
      limp_timing          <= 1'b0;
      limp_safe_since      <= '0;
      soft_stop_since      <= '0;
      recover_window_ms    <= dssm_pkg::LIMP_RECOVER_RST;
      soft_stop_timeout_ms <= dssm_pkg::SOFT_TIMEOUT_RST;
    end else begin
      if (step) begin
        mode            <= mode_next;
        limp_timing     <= limp_timing_next;
        limp_safe_since <= limp_safe_since_next;
        soft_stop_since <= soft_stop_since_next;
      end
      if (cfg_we && (cfg_addr == dssm_pkg::REG_LIMP_RECOVER)) begin
        recover_window_ms <= cfg_data;
      end
      if (cfg_we && (cfg_addr == dssm_pkg::REG_SOFT_TIMEOUT)) begin
        soft_stop_timeout_ms <= cfg_data;
      end
    end
  end

  // locked only leaves through reset
  a_locked_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == dssm_pkg::MODE_LOCKED) |=> (mode == dssm_pkg::MODE_LOCKED))
    else $error("locked mode left without reset");

  // entering soft stop records the tick time
  a_soft_start: assert property (@(posedge clk) disable iff (rst)
    (step && (mode != dssm_pkg::MODE_SOFT_STOP) && (mode_next == dssm_pkg::MODE_SOFT_STOP))
    |=> (soft_stop_since == $past(item.now_ms)))
    else $error("soft stop start time not captured");

  // idle ticks drive zero and request a ramp clear
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (step && (mode == dssm_pkg::MODE_IDLE)) |->
    (res.clear_ramps && (res.target_left == 16'sd0) && (res.target_right == 16'sd0)))
    else $error("idle tick with nonzero target or no ramp clear");

  // mode only moves on a tick
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(mode))
    else $error("mode changed without a tick");

endmodule

FILE: src/drive_safety_state_machine.sv
// ----------------------------------------------------------------------------
// drive_safety_state_machine
// Five-mode drive safety supervisor with mode-scaled drive targets.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one control tick per transfer (time, active flag, safety
//          level, drive demands and measured outputs).
//   out_ch returns exactly one result per tick, in order: the two targets,
//          the mode after the tick and the ramp clear request.
//   cfg    writes the limp recovery window (address 0) or soft_stop_timeout_ms
//          (address 1); other addresses are dropped. Always ready; write
//          only while no tick is in flight.
// The input transfer loads the input register, then the mode logic feeds the
// result register, from which out_ch transfers. One tick per cycle is
// sustained while out_ch is ready; the rate is set by the single mode
// update path.
// When out_ch stalls, the result register holds and the input register takes
// one more tick before in_ch.ready drops.
// Reset (rst, synchronous) empties both registers, returns to idle and
// restores the register defaults of 1000 ms and 2000 ms.
// ----------------------------------------------------------------------------
module drive_safety_state_machine (
  input  logic     clk,
  input  logic     rst,
  dssm_in_if.sink  in_ch,
  dssm_out_if.source out_ch,
  dssm_cfg_if.sink cfg
);

  dssm_pkg::in_item_t  in_q;
  logic                in_valid;
  dssm_pkg::out_item_t res;
  dssm_pkg::out_item_t out_q;
  logic                out_valid;
  logic                advance;

  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q.now_ms        <= in_ch.now_ms;
      in_q.system_active <= in_ch.system_active;
      in_q.safety_level  <= in_ch.safety_level;
      in_q.demand_left   <= in_ch.demand_left;
      in_q.demand_right  <= in_ch.demand_right;
      in_q.actual_left   <= in_ch.actual_left;
      in_q.actual_right  <= in_ch.actual_right;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  dssm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (in_q),
    .res      (res),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_addr (cfg.addr),
    .cfg_data (cfg.data)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.target_left  = out_q.target_left;
  assign out_ch.target_right = out_q.target_right;
  assign out_ch.drive_mode   = out_q.drive_mode;
  assign out_ch.clear_ramps  = out_q.clear_ramps;

endmodule
